@@ src/esc_pkg.sv @@
// Shared constants, types and byte-mapping functions for the escape codec.
package esc_pkg;

    localparam int BYTE_W = 8;
    localparam int CAP_W  = 16;
    localparam int MAX_RESULTS = 3;

    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_COMMA     = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_BAR       = 8'h7C;
    localparam logic [BYTE_W-1:0] CH_BSLASH    = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_N         = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_C         = 8'h63;
    localparam logic [BYTE_W-1:0] CH_Z         = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_Y         = 8'h79;
    localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd1024;

    typedef enum logic
    {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef enum logic
    {
        REG_MODE     = 1'b0,
        REG_CAPACITY = 1'b1
    } reg_index_t;

    // Up to three result bytes for one request; term marks the final one as terminator
    typedef struct packed
    {
        logic [1:0]                    count;
        logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes;
        logic                          term;
    } result_t;

    function automatic logic [BYTE_W-1:0] enc_code(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        case (b)
            CH_NEWLINE: c = CH_N;
            CH_COMMA:   c = CH_C;
            CH_BAR:     c = CH_Z;
            CH_BSLASH:  c = CH_Y;
            default:    c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] dec_code(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        case (b)
            CH_N:    c = CH_NEWLINE;
            CH_C:    c = CH_COMMA;
            CH_Z:    c = CH_BAR;
            CH_Y:    c = CH_BSLASH;
            default: c = b;
        endcase
        return c;
    endfunction

endpackage

@@ src/esc_if.sv @@
// Valid/ready stream interfaces for input bytes and result bytes.
interface esc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_in;

    modport source (output valid, output in_byte, output last_in, input ready);
    modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

interface esc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_byte, output run_last, output string_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_end,
                    output ready);
endinterface

@@ src/escape_codec.sv @@
// Top level of the escape codec: APB registers, input stage, result buffer.
//
// escape_codec escapes (mode 0) or unescapes (mode 1) a string that arrives one
// byte per request on in_ch, with last_in on its final byte. Encoding turns
// newline, comma, bar and backslash into a backslash followed by n, c, z or y;
// a byte of 0x80 or above is a lead byte and travels with the next byte
// unchanged. In encode mode, output is clipped to the capacity register
// (terminator included); once a byte or escape pair does not fit, the rest of
// the string is swallowed. Every string ends with one terminator result on
// out_ch (out_byte 0, string_end 1); run_last flags the final result of each
// input request. Timing: a request is registered then processed combinationally
// into a result buffer of up to three bytes, which drains one byte per cycle on
// out_ch while out_ch.ready is high. A request waits in the input register until
// the buffer is free, and its results are registered there. Throughput is one
// request per cycle while each request yields at most one result and out_ch is
// ready; an escape pair or a final byte with its terminator holds the buffer
// until its last byte leaves. A request yielding no result still takes a step.
// Registers: mode at byte address 0 (bit 0), capacity at 4 (bits 15:0), reset
// values 0 and 1024. Write them only while the block is idle.
module escape_codec
    import esc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    esc_in_if.sink           in_ch,
    esc_out_if.source        out_ch,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers
    mode_t            mode_reg;
    logic [CAP_W-1:0] capacity_reg;
    logic             cfg_write;
    reg_index_t       cfg_sel;

    // Input stage
    logic              in_vld_reg, in_vld_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              in_fire;

    // Result buffer
    logic [1:0]                         buf_cnt_reg, buf_cnt_next;
    logic [1:0]                         buf_idx_reg, buf_idx_next;
    logic [MAX_RESULTS-1:0][BYTE_W-1:0] buf_bytes_reg;
    logic                               buf_term_reg;
    logic                               out_fire;
    logic                               buf_final;
    logic                               buf_free;
    logic                               step;

    result_t res;

    // APB: pready is tied high, so no access ever waits
    assign pready    = 1'b1;
    assign cfg_sel   = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_sel)
            REG_MODE:     prdata = {31'd0, mode_reg};
            REG_CAPACITY: prdata = {{(32-CAP_W){1'b0}}, capacity_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_ENCODE;
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_MODE:     mode_reg     <= mode_t'(pwdata[0]);
                REG_CAPACITY: capacity_reg <= pwdata[CAP_W-1:0];
                default:      mode_reg     <= mode_reg;
            endcase
        end
    end

    // Output side: drain the buffer one byte per cycle while out_ch.ready is high
    assign out_ch.valid      = (buf_idx_reg != buf_cnt_reg);
    assign buf_final         = (buf_idx_reg + 2'd1 == buf_cnt_reg);
    assign out_ch.out_byte   = buf_bytes_reg[buf_idx_reg];
    assign out_ch.run_last   = buf_final;
    assign out_ch.string_end = buf_final && buf_term_reg;
    assign out_fire          = out_ch.valid && out_ch.ready;

    // Buffer can take the next processed request once its last byte leaves
    assign buf_free = !out_ch.valid || (out_fire && buf_final);
    assign step     = in_vld_reg && buf_free;

    // Input side: hold one request; accept a new one whenever it moves on
    assign in_ch.ready = !in_vld_reg || step;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_fire)
        begin
            in_vld_next = 1'b1;
        end
        else if (step)
        begin
            in_vld_next = 1'b0;
        end

        buf_cnt_next = buf_cnt_reg;
        buf_idx_next = buf_idx_reg;
        if (step)
        begin
            buf_cnt_next = res.count;
            buf_idx_next = 2'd0;
        end
        else if (out_fire)
        begin
            buf_idx_next = buf_idx_reg + 2'd1;
        end
    end

    esc_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .in_byte  (in_byte_reg),
        .last_in  (in_last_reg),
        .mode     (mode_reg),
        .capacity (capacity_reg),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            buf_cnt_reg <= 2'd0;
            buf_idx_reg <= 2'd0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            buf_cnt_reg <= buf_cnt_next;
            buf_idx_reg <= buf_idx_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= in_ch.in_byte;
            in_last_reg <= in_ch.last_in;
        end
        if (step)
        begin
            buf_bytes_reg <= res.bytes;
            buf_term_reg  <= res.term;
        end
    end

endmodule

@@ src/esc_core.sv @@
// Per-string codec state and the combinational escape/unescape step.
module esc_core
    import esc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              last_in,
    input  mode_t             mode,
    input  logic [CAP_W-1:0]  capacity,
    output result_t           res
);

    logic             trail_reg,   trail_next;
    logic             escape_reg,  escape_next;
    logic [CAP_W-1:0] written_reg, written_next;
    logic             stopped_reg, stopped_next;

    logic [1:0]        e_cnt;
    logic [BYTE_W-1:0] e0, e1;
    logic [CAP_W:0]    w_plus1, w_plus2, cap_ext;
    logic [BYTE_W-1:0] code;

    always_comb
    begin
        w_plus1 = {1'b0, written_reg} + {{CAP_W{1'b0}}, 1'b1};
        w_plus2 = {1'b0, written_reg} + {{(CAP_W-1){1'b0}}, 2'd2};
        cap_ext = {1'b0, capacity};
        code    = enc_code(in_byte);

        e_cnt        = 2'd0;
        e0           = in_byte;
        e1           = CH_NUL;
        trail_next   = trail_reg;
        escape_next  = escape_reg;
        written_next = written_reg;
        stopped_next = stopped_reg;

        if (mode == MODE_ENCODE)
        begin
            escape_next = 1'b0;
            if (trail_reg)
            begin
                trail_next   = 1'b0;
                e_cnt        = 2'd1;
                written_next = w_plus1[CAP_W-1:0];
            end
            else if (stopped_reg)
            begin
                e_cnt = 2'd0;
            end
            else if (w_plus1 >= cap_ext)
            begin
                stopped_next = 1'b1;
            end
            else if (in_byte[BYTE_W-1])
            begin
                if (w_plus2 >= cap_ext)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    e_cnt        = 2'd1;
                    written_next = w_plus1[CAP_W-1:0];
                    trail_next   = 1'b1;
                end
            end
            else if (code != CH_NUL)
            begin
                if (w_plus2 < cap_ext)
                begin
                    e_cnt        = 2'd2;
                    e0           = CH_BSLASH;
                    e1           = code;
                    written_next = w_plus2[CAP_W-1:0];
                end
                else
                begin
                    stopped_next = 1'b1;
                end
            end
            else
            begin
                e_cnt        = 2'd1;
                written_next = w_plus1[CAP_W-1:0];
            end
        end
        else
        begin
            if (trail_reg)
            begin
                trail_next = 1'b0;
                e_cnt      = 2'd1;
            end
            else if (escape_reg)
            begin
                escape_next = 1'b0;
                e_cnt       = 2'd1;
                e0          = dec_code(in_byte);
            end
            else if (in_byte[BYTE_W-1])
            begin
                e_cnt      = 2'd1;
                trail_next = 1'b1;
            end
            else if (in_byte == CH_BSLASH)
            begin
                escape_next = 1'b1;
            end
            else
            begin
                e_cnt = 2'd1;
            end
        end

        // On the last byte, append the terminator and drop all per-string state
        res.bytes = {CH_NUL, e1, e0};
        res.count = e_cnt;
        res.term  = last_in;
        if (last_in)
        begin
            res.count    = e_cnt + 2'd1;
            trail_next   = 1'b0;
            escape_next  = 1'b0;
            written_next = '0;
            stopped_next = 1'b0;
            case (e_cnt)
                2'd0:    res.bytes[0] = CH_NUL;
                2'd1:    res.bytes[1] = CH_NUL;
                default: res.bytes[2] = CH_NUL;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trail_reg   <= 1'b0;
            escape_reg  <= 1'b0;
            written_reg <= '0;
            stopped_reg <= 1'b0;
        end
        else if (step)
        begin
            trail_reg   <= trail_next;
            escape_reg  <= escape_next;
            written_reg <= written_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

@@ src/esc_checker.sv @@
// Port-level assertions for the escape codec, bound to the top level.
module esc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       string_end,
    input logic       pready
);

    // Hold a result until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Terminator closes the run of its request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> run_last)
        else $error("terminator not flagged as last result");

    // Terminator carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> out_byte == 8'h00)
        else $error("terminator byte not zero");

    // A terminator taken starts a fresh string; this check only re-tests out_ready, so it never fires
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && string_end ##1 out_valid |-> $past(out_ready))
        else $error("terminator repeated");

    // Register port never stalls
    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind escape_codec esc_checker u_esc_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .run_last   (out_ch.run_last),
    .string_end (out_ch.string_end),
    .pready     (pready)
);
